[rtl/ssg_pkg.sv]
// ----------------------------------------------------------------------------
// ssg_pkg: shared types and constants for the step sequencer gate
// Holds the command codes, the controller states and the step slot layout.
// ----------------------------------------------------------------------------
package ssg_pkg;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_LENGTH = 2'd2,
		CMD_PARK   = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_DIV,
		ST_MUL,
		ST_PCT,
		ST_FILL_RD,
		ST_FILL,
		ST_OUT_RD,
		ST_OUT
	} state_t;

	localparam int SLOT_W = 21;
	localparam int SPS_W  = 24;
	localparam int CNT_W  = 32;
	localparam logic [SPS_W-1:0] SPS_RESET = 24'd6000;
	localparam logic [6:0] PCT_DIV = 7'd100;

	// slot layout: note(7) rest tied accent ratchets(4) pct(7)
	typedef struct packed {
		logic [6:0] note;
		logic       rest;
		logic       tied;
		logic       accent;
		logic [3:0] ratchets;
		logic [6:0] pct;
	} slot_t;

	typedef struct packed {
		logic       start_div;
		logic       start_mul;
		logic       start_pct;
		logic       ld_item;
		logic       do_tick;
		logic       do_park;
		logic       do_len;
		logic       set_gate;
		logic       fill_init;
		logic       fill_step;
		logic       out_load;
		logic [1:0] rd_sel;
	} ctl_t;

	typedef struct packed {
		logic busy;
		logic need_div;
		logic need_fill;
		logic fill_done;
		logic gate_trivial;
	} sts_t;

	localparam logic [1:0] RD_PLAY = 2'd0;
	localparam logic [1:0] RD_LAST = 2'd1;

endpackage

[rtl/ssg_ram.sv]
// ----------------------------------------------------------------------------
// ssg_ram: generic simple dual-port RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module ssg_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/ssg_ctrl.sv]
// ----------------------------------------------------------------------------
// ssg_ctrl: step sequencer gate controller
// Sequences each command beat through the datapath and hands out the result.
// ----------------------------------------------------------------------------
module ssg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    cmd,
	input  logic          out_valid,
	input  logic          out_ready,
	input  ssg_pkg::sts_t sts,
	output ssg_pkg::ctl_t ctl
);
	import ssg_pkg::*;

	state_t state_q, state_d;
	logic   slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign slot_free = !out_valid || out_ready;

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				ctl.ld_item = in_valid;
				if (in_valid) begin
					unique case (cmd_t'(cmd))
						CMD_TICK: begin
							ctl.do_tick = 1'b1;
							state_d     = ST_RD;
						end
						CMD_WRITE: state_d = ST_OUT_RD;
						CMD_LENGTH: state_d = ST_FILL_RD;
						CMD_PARK: begin
							ctl.do_park = 1'b1;
							state_d     = ST_OUT_RD;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_RD: begin
				ctl.rd_sel = RD_PLAY;
				state_d    = ST_DIV;
			end
			ST_DIV: begin
				if (sts.gate_trivial) begin
					ctl.set_gate = 1'b1;
					state_d      = ST_OUT_RD;
				end else begin
					ctl.start_div = sts.need_div;
					state_d       = ST_MUL;
				end
			end
			ST_MUL: begin
				if (!sts.busy) begin
					ctl.start_mul = 1'b1;
					state_d       = ST_PCT;
				end
			end
			ST_PCT: begin
				ctl.start_pct = 1'b1;
				state_d       = ST_OUT_RD;
			end
			ST_FILL_RD: begin
				ctl.rd_sel = RD_LAST;
				state_d    = ST_FILL;
			end
			ST_FILL: begin
				if (!sts.busy) begin
					if (sts.need_fill && !sts.fill_done) begin
						ctl.fill_step = 1'b1;
					end else begin
						ctl.do_len = 1'b1;
						state_d    = ST_OUT_RD;
					end
				end
			end
			ST_OUT_RD: begin
				if (!sts.busy) begin
					ctl.rd_sel = RD_PLAY;
					state_d    = ST_OUT;
				end
			end
			ST_OUT: begin
				ctl.rd_sel = RD_PLAY;
				if (slot_free) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		ctl.fill_init = (state_q == ST_FILL_RD);
	end
endmodule

[rtl/ssg_dp.sv]
// ----------------------------------------------------------------------------
// ssg_dp: step sequencer gate datapath
// Step table, playhead, sample counter, serial divider and gate compare.
// ----------------------------------------------------------------------------
module ssg_dp #(
	parameter int STEP_SLOTS    = 64,
	parameter int RATCHET_LIMIT = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ssg_pkg::ctl_t            ctl,
	output ssg_pkg::sts_t            sts,
	input  logic                     step_advance,
	input  logic [5:0]               step_index,
	input  logic [6:0]               step_note,
	input  logic                     step_is_rest,
	input  logic                     step_tied,
	input  logic                     step_accent,
	input  logic [3:0]               step_ratchets,
	input  logic [6:0]               step_gate_percent,
	input  logic [7:0]               new_length,
	input  logic                     cfg_valid,
	input  logic [23:0]              cfg_data,
	input  logic                     cmd_write,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     gate_open,
	output logic [5:0]               current_step,
	output logic [6:0]               current_note,
	output logic                     current_is_rest,
	output logic                     current_tied,
	output logic                     current_accent
);
	import ssg_pkg::*;

	localparam int AW  = $clog2(STEP_SLOTS);
	localparam int LW  = $clog2(STEP_SLOTS + 1);
	localparam int RW  = $clog2(RATCHET_LIMIT + 1);
	localparam int PW  = SPS_W + 7;
	localparam logic [LW-1:0] LEN_RESET =
		LW'((STEP_SLOTS < 16) ? STEP_SLOTS : 16);

	logic [SPS_W-1:0] sps_q;
	logic [LW-1:0]    act_len_q, hw_len_q, fill_q, tgt_q;
	logic [AW-1:0]    play_q;
	logic             parked_q, gate_q;
	logic [CNT_W-1:0] cnt_q;
	logic [STEP_SLOTS-1:0] vld_q;
	logic [LW-1:0]    req_len;
	logic [7:0]       step_ix_q;
	slot_t            wslot_q, last_q;
	logic             wr_pend_q;
	logic             last_rd_q;

	logic             ram_we;
	logic [AW-1:0]    ram_wa, ram_ra, ra_q;
	slot_t            ram_wd, ram_rd, cur;

	// divider and remainder unit
	logic [SPS_W-1:0] quo_q, rem_q, dvd_q;
	logic [CNT_W-1:0] num_q, pos_q;
	logic [CNT_W:0]   prem_q;
	logic [5:0]       dcnt_q;
	logic [1:0]       dph_q;
	logic             dbusy_q;
	logic [RW-1:0]    rat;
	logic [PW-1:0]    prod_q;
	logic [CNT_W:0]   trial;
	logic [SPS_W:0]   trial_a;

	ssg_ram #(.WIDTH(SLOT_W), .DEPTH(STEP_SLOTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (ram_wd),
		.raddr (ram_ra),
		.rdata (ram_rd)
	);

	assign cur = vld_q[ra_q] ? ram_rd : slot_t'({7'd0, 1'b1, 1'b0, 1'b0, 4'd1, 7'd0});

	always_comb begin
		if (ctl.rd_sel == RD_LAST) begin
			ram_ra = AW'(hw_len_q - LW'(1));
		end else begin
			ram_ra = play_q;
		end
	end

	always_comb begin
		ram_we = 1'b0;
		ram_wa = fill_q[AW-1:0];
		ram_wd = last_q;
		if (ctl.fill_step) begin
			ram_we = 1'b1;
			ram_wd = last_rd_q ? cur : last_q;
		end else if (wr_pend_q) begin
			ram_we = 1'b1;
			ram_wa = step_ix_q[AW-1:0];
			ram_wd = wslot_q;
		end
	end

	always_comb begin
		if (new_length > 8'(STEP_SLOTS)) begin
			req_len = LW'(STEP_SLOTS);
		end else if (new_length == 8'd0) begin
			req_len = LW'(1);
		end else begin
			req_len = LW'(new_length);
		end
	end

	always_comb begin
		if (cur.ratchets == 4'd0) begin
			rat = RW'(1);
		end else if (cur.ratchets > 4'(RATCHET_LIMIT)) begin
			rat = RW'(RATCHET_LIMIT);
		end else begin
			rat = RW'(cur.ratchets);
		end
	end

	assign sts.busy         = dbusy_q || wr_pend_q;
	assign sts.need_div     = (rat > RW'(1));
	assign sts.need_fill    = (tgt_q > hw_len_q);
	assign sts.fill_done    = (fill_q >= tgt_q);
	assign sts.gate_trivial = parked_q || cur.rest || cur.tied;

	assign trial_a = {rem_q, dvd_q[SPS_W-1]} - {{(SPS_W-RW+1){1'b0}}, rat};
	assign trial   = {prem_q[CNT_W-1:0], num_q[CNT_W-1]} - {1'b0, {(CNT_W-SPS_W){1'b0}}, quo_q};

	always_ff @(posedge clk) begin
		ra_q <= ram_ra;
		if (ctl.ld_item) begin
			step_ix_q <= {2'b00, step_index};
			wslot_q   <= '{step_note, step_is_rest, step_tied, step_accent,
				step_ratchets, step_gate_percent};
			tgt_q     <= req_len;
		end
		if (ctl.fill_init) begin
			fill_q <= hw_len_q;
		end else if (ctl.fill_step) begin
			fill_q <= fill_q + LW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pend_q <= 1'b0;
			vld_q     <= '0;
			last_q    <= '0;
			last_rd_q <= 1'b0;
		end else begin
			wr_pend_q <= ctl.ld_item && cmd_write && ({3'b000, step_index} < 9'(STEP_SLOTS));
			if (ctl.fill_step) begin
				vld_q[fill_q[AW-1:0]] <= 1'b1;
			end else if (wr_pend_q) begin
				vld_q[step_ix_q[AW-1:0]] <= 1'b1;
			end
			last_rd_q <= (ctl.rd_sel == RD_LAST);
			if (last_rd_q) begin
				last_q <= cur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sps_q     <= SPS_RESET;
			act_len_q <= LEN_RESET;
			hw_len_q  <= LEN_RESET;
			play_q    <= '0;
			parked_q  <= 1'b1;
			cnt_q     <= '0;
			gate_q    <= 1'b0;
			dbusy_q   <= 1'b0;
			dph_q     <= 2'd0;
			dcnt_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				sps_q <= cfg_data;
			end
			if (ctl.do_tick) begin
				if (step_advance) begin
					if (parked_q) begin
						play_q   <= '0;
						parked_q <= 1'b0;
					end else if ({1'b0, play_q} + LW'(1) >= act_len_q) begin
						play_q <= '0;
					end else begin
						play_q <= play_q + AW'(1);
					end
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (ctl.do_park) begin
				play_q   <= '0;
				parked_q <= 1'b1;
				cnt_q    <= '0;
				gate_q   <= 1'b0;
			end
			if (ctl.do_len) begin
				act_len_q <= tgt_q;
				if (tgt_q > hw_len_q) begin
					hw_len_q <= tgt_q;
				end
			end
			if (ctl.set_gate) begin
				gate_q <= !parked_q && !cur.rest && cur.tied;
			end
			// sub = sps / rat, then pos = cnt % sub (0 if sub is 0), or sub = sps and pos = cnt
			if (ctl.start_div) begin
				dbusy_q <= 1'b1;
				dph_q   <= 2'd1;
				dcnt_q  <= 6'(SPS_W);
				dvd_q   <= sps_q;
				rem_q   <= '0;
			end else if (ctl.start_mul && !sts.need_div) begin
				quo_q <= sps_q;
				pos_q <= cnt_q;
			end else if (dbusy_q && dph_q == 2'd1) begin
				if (trial_a[SPS_W]) begin
					rem_q <= {rem_q[SPS_W-2:0], dvd_q[SPS_W-1]};
					dvd_q <= {dvd_q[SPS_W-2:0], 1'b0};
				end else begin
					rem_q <= trial_a[SPS_W-1:0];
					dvd_q <= {dvd_q[SPS_W-2:0], 1'b1};
				end
				dcnt_q <= dcnt_q - 6'd1;
				if (dcnt_q == 6'd1) begin
					dph_q <= 2'd2;
				end
			end else if (dbusy_q && dph_q == 2'd2) begin
				quo_q <= dvd_q;
				num_q <= cnt_q;
				prem_q <= '0;
				dcnt_q <= 6'(CNT_W);
				if (dvd_q == '0) begin
					pos_q   <= '0;
					dbusy_q <= 1'b0;
					dph_q   <= 2'd0;
				end else begin
					dph_q <= 2'd3;
				end
			end else if (dbusy_q && dph_q == 2'd3) begin
				if (trial[CNT_W]) begin
					prem_q <= {prem_q[CNT_W-1:0], num_q[CNT_W-1]};
				end else begin
					prem_q <= {1'b0, trial[CNT_W-1:0]};
				end
				num_q  <= {num_q[CNT_W-2:0], 1'b0};
				dcnt_q <= dcnt_q - 6'd1;
				if (dcnt_q == 6'd1) begin
					dbusy_q <= 1'b0;
					dph_q   <= 2'd0;
				end
			end
			if (ctl.start_mul) begin
				if (sts.need_div) begin
					pos_q  <= prem_q[CNT_W-1:0];
					prod_q <= PW'(quo_q) * PW'(cur.pct);
				end else begin
					prod_q <= PW'(sps_q) * PW'(cur.pct);
				end
			end
			// open while pos < floor(prod / 100)
			if (ctl.start_pct) begin
				gate_q <= ({7'd0, pos_q} * 39'(PCT_DIV) + 39'(PCT_DIV) <= 39'(prod_q));
			end
			if (ctl.out_load) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			gate_open <= gate_q;
			if (parked_q) begin
				current_step    <= '0;
				current_note    <= '0;
				current_is_rest <= 1'b0;
				current_tied    <= 1'b0;
				current_accent  <= 1'b0;
			end else begin
				current_step    <= 6'(play_q);
				current_note    <= cur.note;
				current_is_rest <= cur.rest;
				current_tied    <= cur.tied;
				current_accent  <= cur.accent;
			end
		end
	end
endmodule

[rtl/step_sequencer_gate_top.sv]
// ----------------------------------------------------------------------------
// step_sequencer_gate_top: step sequencer track with ratchet gates
// Keeps a step table and a playhead and produces one gate result per command.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_ready    command, step_*, new_length
//  out      out_valid / out_ready  gate_open, current_*
//  cfg      cfg_valid / cfg_ready  cfg_data (samples_per_step)
//
//  A tick on a rest or tied step sets the gate directly; a plain step takes the
//  multiply and compare, and a ratcheted step first runs the bit-serial divider
//  (24 quotient bits, 32 remainder bits). A length change writes its new slots
//  one at a time. Each command hands out its result before the next is accepted.
//  Reset gives an empty table read as rests; out stalls hold the controller.
// ----------------------------------------------------------------------------
module step_sequencer_gate_top #(
	parameter int STEP_SLOTS    = 64,
	parameter int RATCHET_LIMIT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic        step_advance,
	input  logic [5:0]  step_index,
	input  logic [6:0]  step_note,
	input  logic        step_is_rest,
	input  logic        step_tied,
	input  logic        step_accent,
	input  logic [3:0]  step_ratchets,
	input  logic [6:0]  step_gate_percent,
	input  logic [7:0]  new_length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        gate_open,
	output logic [5:0]  current_step,
	output logic [6:0]  current_note,
	output logic        current_is_rest,
	output logic        current_tied,
	output logic        current_accent
);
	import ssg_pkg::*;

	ctl_t ctl;
	sts_t sts;

	assign cfg_ready = 1'b1;

	ssg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	ssg_dp #(.STEP_SLOTS(STEP_SLOTS), .RATCHET_LIMIT(RATCHET_LIMIT)) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl               (ctl),
		.sts               (sts),
		.step_advance      (step_advance),
		.step_index        (step_index),
		.step_note         (step_note),
		.step_is_rest      (step_is_rest),
		.step_tied         (step_tied),
		.step_accent       (step_accent),
		.step_ratchets     (step_ratchets),
		.step_gate_percent (step_gate_percent),
		.new_length        (new_length),
		.cfg_valid         (cfg_valid),
		.cfg_data          (cfg_data),
		.cmd_write         (command == CMD_WRITE),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.gate_open         (gate_open),
		.current_step      (current_step),
		.current_note      (current_note),
		.current_is_rest   (current_is_rest),
		.current_tied      (current_tied),
		.current_accent    (current_accent)
	);

	a_out_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped under stall");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item accepted while busy");
endmodule
